// ===== src/kdlp_pkg.sv =====
`timescale 1ns / 1ps

package kdlp_pkg;

  // Field widths
  localparam int CODE_W  = 16;
  localparam int TICK_W  = 16;
  localparam int KIND_W  = 2;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  // Hold period between held events, in ticks
  localparam int HELD_PERIOD = 100;
  localparam int MOD_W       = $clog2(HELD_PERIOD + 1);

  // Saturation value of the tick counters
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // Event kinds
  localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] EV_HELD    = 2'd1;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

  // Register indexes (byte address is 4 times the index)
  localparam logic [1:0] REG_FILTER_TICKS  = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS_EN = 2'd1;
  localparam logic [1:0] REG_RELEASED_CODE = 2'd2;

  // Reset values of the registers
  localparam logic [TICK_W-1:0] FILTER_TICKS_RST = 16'd3;

endpackage

// ===== src/key_debounce_long_press_core.sv =====
`timescale 1ns / 1ps

// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------------
// scan in   | scan_valid / scan_ready    | scan_code
// event out | event_valid / event_ready  | event_kind, event_ticks, event_key
// config    | APB psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// One scan request per cycle while scan_ready is high; the debounce state updates at the
// accepting edge, and an event, if any, is registered at that edge unless the output is stalled.
// A skid register behind the output register takes one event while the output
// is stalled; scan_ready drops only while that skid register is full.
// Synchronous reset clears the debounce state and both event valid flags and
// restores the register defaults.

module key_debounce_long_press_core (
  input  logic                        clk,
  input  logic                        rst,
  // scan channel
  input  logic                        scan_valid,
  output logic                        scan_ready,
  input  logic [kdlp_pkg::CODE_W-1:0] scan_code,
  // event channel
  output logic                        event_valid,
  input  logic                        event_ready,
  output logic [kdlp_pkg::KIND_W-1:0] event_kind,
  output logic [kdlp_pkg::TICK_W-1:0] event_ticks,
  output logic [kdlp_pkg::CODE_W-1:0] event_key,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kdlp_pkg::ADDR_W-1:0] paddr,
  input  logic [kdlp_pkg::DATA_W-1:0] pwdata,
  output logic [kdlp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  typedef enum logic [1:0] {
    PH_RELEASED     = 2'd0,
    PH_REL_FILTER   = 2'd1,
    PH_PRESSED      = 2'd2,
    PH_PRESS_FILTER = 2'd3
  } phase_t;

  typedef struct packed {
    logic [kdlp_pkg::KIND_W-1:0] kind;
    logic [kdlp_pkg::TICK_W-1:0] ticks;
    logic [kdlp_pkg::CODE_W-1:0] key;
  } event_t;

  // Configuration registers
  logic [kdlp_pkg::TICK_W-1:0] filter_ticks;
  logic                        long_press_enable;
  logic [kdlp_pkg::CODE_W-1:0] released_code;

  // Debounce state
  phase_t                      phase, phase_next;
  logic [kdlp_pkg::CODE_W-1:0] candidate_code;
  logic [kdlp_pkg::TICK_W-1:0] stable_count, stable_count_next;
  logic [kdlp_pkg::MOD_W-1:0]  stable_mod, stable_mod_next;
  logic [kdlp_pkg::TICK_W-1:0] held_count, held_count_next;
  logic [kdlp_pkg::MOD_W-1:0]  held_mod, held_mod_next;
  logic [kdlp_pkg::CODE_W-1:0] confirmed_code, confirmed_code_next;

  // Output and skid registers
  event_t                      out_event;
  event_t                      skid_event;
  logic                        skid_valid;

  logic                        accept;
  logic                        change;
  logic [kdlp_pkg::TICK_W-1:0] base_count, count_inc;
  logic [kdlp_pkg::MOD_W-1:0]  base_mod, mod_inc;
  logic                        not_sat;
  logic                        fire;
  event_t                      new_event;
  logic                        out_free;
  logic                        cfg_write;

  assign accept     = scan_valid && scan_ready;
  assign scan_ready = !skid_valid;
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;

  assign event_kind  = out_event.kind;
  assign event_ticks = out_event.ticks;
  assign event_key   = out_event.key;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_ticks      <= kdlp_pkg::FILTER_TICKS_RST;
      long_press_enable <= 1'b0;
      released_code     <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        kdlp_pkg::REG_FILTER_TICKS:  filter_ticks      <= pwdata[kdlp_pkg::TICK_W-1:0];
        kdlp_pkg::REG_LONG_PRESS_EN: long_press_enable <= pwdata[0];
        kdlp_pkg::REG_RELEASED_CODE: released_code     <= pwdata[kdlp_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[3:2])
      kdlp_pkg::REG_FILTER_TICKS:
        prdata = {{(kdlp_pkg::DATA_W-kdlp_pkg::TICK_W){1'b0}}, filter_ticks};
      kdlp_pkg::REG_LONG_PRESS_EN:
        prdata = {{(kdlp_pkg::DATA_W-1){1'b0}}, long_press_enable};
      kdlp_pkg::REG_RELEASED_CODE:
        prdata = {{(kdlp_pkg::DATA_W-kdlp_pkg::CODE_W){1'b0}}, released_code};
      default:
        prdata = '0;
    endcase
  end

  // Restart the stability count on a code change, then advance it, saturating.
  // The count modulo the hold period is tracked beside it.
  assign change     = scan_code != candidate_code;
  assign base_count = change ? '0 : stable_count;
  assign base_mod   = change ? '0 : stable_mod;
  assign not_sat    = base_count != kdlp_pkg::TICK_MAX;
  assign count_inc  = not_sat ? base_count + 1'b1 : base_count;
  assign mod_inc    = !not_sat ? base_mod :
                      (base_mod == kdlp_pkg::MOD_W'(kdlp_pkg::HELD_PERIOD - 1)) ? '0 :
                      base_mod + 1'b1;

  // Phase transitions and event selection
  always_comb begin
    phase_next          = phase;
    stable_count_next   = count_inc;
    stable_mod_next     = mod_inc;
    held_count_next     = held_count;
    held_mod_next       = held_mod;
    confirmed_code_next = confirmed_code;
    fire                = 1'b0;
    new_event.kind      = kdlp_pkg::EV_PRESS;
    new_event.ticks     = count_inc;
    new_event.key       = confirmed_code;
    unique case (phase)
      PH_RELEASED: begin
        if (change) begin
          phase_next = PH_REL_FILTER;
        end
      end
      PH_REL_FILTER: begin
        if (change) begin
          phase_next = PH_RELEASED;
        end else if (count_inc >= filter_ticks) begin
          held_count_next     = count_inc;
          held_mod_next       = mod_inc;
          confirmed_code_next = scan_code;
          fire                = 1'b1;
          new_event.kind      = kdlp_pkg::EV_PRESS;
          new_event.ticks     = count_inc;
          new_event.key       = scan_code;
          phase_next          = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (change) begin
          phase_next = PH_PRESS_FILTER;
        end else begin
          held_count_next = count_inc;
          held_mod_next   = mod_inc;
          fire            = long_press_enable && (mod_inc == '0);
          new_event.kind  = kdlp_pkg::EV_HELD;
        end
      end
      PH_PRESS_FILTER: begin
        if (change) begin
          // glitch: restore the stability count from the hold time
          stable_count_next = held_count;
          stable_mod_next   = held_mod;
          if (confirmed_code == scan_code) begin
            phase_next = PH_PRESSED;
          end
        end else if (count_inc >= filter_ticks) begin
          fire                = 1'b1;
          new_event.kind      = kdlp_pkg::EV_RELEASE;
          new_event.ticks     = held_count;
          new_event.key       = confirmed_code;
          held_count_next     = '0;
          held_mod_next       = '0;
          confirmed_code_next = scan_code;
          phase_next          = (scan_code == released_code) ? PH_RELEASED : PH_REL_FILTER;
        end
      end
      default: ;
    endcase
  end

  // Advance the debounce state on each accepted scan request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_RELEASED;
      candidate_code <= '0;
      stable_count   <= '0;
      stable_mod     <= '0;
      held_count     <= '0;
      held_mod       <= '0;
      confirmed_code <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      candidate_code <= scan_code;
      stable_count   <= stable_count_next;
      stable_mod     <= stable_mod_next;
      held_count     <= held_count_next;
      held_mod       <= held_mod_next;
      confirmed_code <= confirmed_code_next;
    end
  end

  assign out_free = !event_valid || event_ready;

  // Output and skid valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        event_valid <= 1'b1;
        skid_valid  <= 1'b0;
      end else begin
        event_valid <= accept && fire;
      end
    end else if (accept && fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_event <= skid_valid ? skid_event : new_event;
    end
    if (!out_free && !skid_valid) begin
      skid_event <= new_event;
    end
  end

endmodule

// ===== src/kdlp_checker.sv =====
`timescale 1ns / 1ps

module kdlp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        scan_valid,
  input logic                        scan_ready,
  input logic [kdlp_pkg::CODE_W-1:0] scan_code,
  input logic                        event_valid,
  input logic                        event_ready,
  input logic [kdlp_pkg::KIND_W-1:0] event_kind,
  input logic [kdlp_pkg::TICK_W-1:0] event_ticks,
  input logic [kdlp_pkg::CODE_W-1:0] event_key,
  input logic                        pready
);

  // Hold a stalled event unchanged
  a_event_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_ready |=> event_valid && $stable(event_kind) &&
      $stable(event_ticks) && $stable(event_key))
    else $error("stalled event changed");

  // Drop scan_ready only while an event waits at the output
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !scan_ready |-> event_valid)
    else $error("scan_ready low with no event pending");

  // Clear the event output after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !event_valid && scan_ready)
    else $error("event output not cleared by reset");

  // A press or held event always carries a nonzero tick count
  a_press_ticks: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind == kdlp_pkg::EV_PRESS || event_kind == kdlp_pkg::EV_HELD)
      |-> event_ticks != '0)
    else $error("press or held event with zero ticks");

  // Keep the configuration port always ready
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind key_debounce_long_press_core kdlp_checker u_kdlp_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP = 100;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRESS_CHECK,
    ST_HELD,
    ST_RELEASE_CHECK
  } key_state_t;

  typedef struct packed {
    logic [kdlp_pkg::KIND_W-1:0] kind;
    logic [kdlp_pkg::TICK_W-1:0] ticks;
    logic [kdlp_pkg::CODE_W-1:0] key;
  } key_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic scan_valid = 1'b0;
  logic scan_ready;
  logic [kdlp_pkg::CODE_W-1:0] scan_code = '0;
  logic event_valid;
  logic event_ready = 1'b0;
  logic [kdlp_pkg::KIND_W-1:0] event_kind;
  logic [kdlp_pkg::TICK_W-1:0] event_ticks;
  logic [kdlp_pkg::CODE_W-1:0] event_key;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [kdlp_pkg::ADDR_W-1:0] paddr = '0;
  logic [kdlp_pkg::DATA_W-1:0] pwdata = '0;
  logic [kdlp_pkg::DATA_W-1:0] prdata;
  logic pready;

  // Register values as the block holds them
  logic [kdlp_pkg::TICK_W-1:0] filter_cfg = kdlp_pkg::FILTER_TICKS_RST;
  logic long_press_cfg = 1'b0;
  logic [kdlp_pkg::CODE_W-1:0] release_code_cfg = '0;

  // Debounce state as the block should hold it
  key_state_t key_state = ST_IDLE;
  logic [kdlp_pkg::CODE_W-1:0] scan_last = '0;
  logic [kdlp_pkg::TICK_W-1:0] same_ticks = '0;
  logic [kdlp_pkg::TICK_W-1:0] hold_ticks = '0;
  logic [kdlp_pkg::CODE_W-1:0] active_key = '0;

  logic [kdlp_pkg::CODE_W-1:0] scan_backlog[$];
  key_event_t due_events[$];
  key_event_t want_event;
  logic scan_fired = 1'b0;
  int scans_queued = 0;
  int scans_done = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 10;
  int recv_stall_pct = 53;

  key_debounce_long_press_core dut (
    .clk(clk),
    .rst(rst),
    .scan_valid(scan_valid),
    .scan_ready(scan_ready),
    .scan_code(scan_code),
    .event_valid(event_valid),
    .event_ready(event_ready),
    .event_kind(event_kind),
    .event_ticks(event_ticks),
    .event_key(event_key),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("[%0t] event mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Advance the debounce state by one scan tick and queue the event it causes
  task automatic debounce_tick(input logic [kdlp_pkg::CODE_W-1:0] code);
    logic changed;
    logic fire;
    key_event_t ev;
    changed = (code != scan_last);
    fire = 1'b0;
    ev = '0;
    if (changed) begin
      scan_last = code;
      same_ticks = '0;
    end
    if (same_ticks != kdlp_pkg::TICK_MAX) same_ticks++;
    case (key_state)
      ST_IDLE: begin
        if (changed) key_state = ST_PRESS_CHECK;
      end
      ST_PRESS_CHECK: begin
        if (changed) begin
          key_state = ST_IDLE;
        end else if (same_ticks >= filter_cfg) begin
          hold_ticks = same_ticks;
          active_key = scan_last;
          ev = {kdlp_pkg::EV_PRESS, hold_ticks, active_key};
          fire = 1'b1;
          key_state = ST_HELD;
        end
      end
      ST_HELD: begin
        if (changed) begin
          key_state = ST_RELEASE_CHECK;
        end else begin
          hold_ticks = same_ticks;
          if (long_press_cfg && (hold_ticks % kdlp_pkg::HELD_PERIOD) == 0) begin
            ev = {kdlp_pkg::EV_HELD, hold_ticks, active_key};
            fire = 1'b1;
          end
        end
      end
      default: begin
        if (changed) begin
          // glitch: pick up the hold time again
          same_ticks = hold_ticks;
          if (active_key == scan_last) key_state = ST_HELD;
        end else if (same_ticks >= filter_cfg) begin
          ev = {kdlp_pkg::EV_RELEASE, hold_ticks, active_key};
          fire = 1'b1;
          hold_ticks = '0;
          active_key = scan_last;
          key_state = (active_key == release_code_cfg) ? ST_IDLE : ST_PRESS_CHECK;
        end
      end
    endcase
    if (fire) due_events.push_back(ev);
  endtask

  task automatic queue_scan(input logic [kdlp_pkg::CODE_W-1:0] code);
    scan_backlog.push_back(code);
    scans_queued++;
  endtask

  // Queue key strokes with random content, plus some noise and broken strokes
  task automatic queue_key_strokes(input int budget);
    int stop_at;
    int flt;
    int hold;
    int glitch_at;
    logic [kdlp_pkg::CODE_W-1:0] key;
    stop_at = scans_queued + budget;
    flt = (filter_cfg == 0) ? 1 : int'(filter_cfg);
    while (scans_queued < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) queue_scan(kdlp_pkg::CODE_W'($urandom));
      end else begin
        case ($urandom_range(0, 5))
          0: key = '0;
          1: key = '1;
          2: key = release_code_cfg;
          default: key = kdlp_pkg::CODE_W'($urandom);
        endcase
        hold = flt + $urandom_range(0, 3);
        if ($urandom_range(0, 15) == 0) hold = $urandom_range(95, 215);
        else if ($urandom_range(0, 7) == 0) hold = $urandom_range(1, flt);
        glitch_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, hold - 1) : -1;
        for (int i = 0; i < hold; i++) begin
          queue_scan(key);
          if (i == glitch_at) begin
            if ($urandom_range(0, 1) == 1) queue_scan(release_code_cfg);
            else queue_scan(kdlp_pkg::CODE_W'($urandom));
            if ($urandom_range(0, 1) == 1) queue_scan(kdlp_pkg::CODE_W'($urandom));
          end
        end
        hold = ($urandom_range(0, 7) == 0) ? $urandom_range(1, flt) : flt + $urandom_range(0, 3);
        repeat (hold) queue_scan(release_code_cfg);
      end
    end
  endtask

  // Write one register through a setup phase and an access phase
  task automatic write_reg(input logic [1:0] idx, input logic [kdlp_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      kdlp_pkg::REG_FILTER_TICKS: filter_cfg = value[kdlp_pkg::TICK_W-1:0];
      kdlp_pkg::REG_LONG_PRESS_EN: long_press_cfg = value[0];
      kdlp_pkg::REG_RELEASED_CODE: release_code_cfg = value[kdlp_pkg::CODE_W-1:0];
      default: ;
    endcase
  endtask

  // Hold until every request is taken and every event is out, then let the block settle
  task automatic wait_drained;
    @(negedge clk);
    while (scans_done != scans_queued || due_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Drive requests: hold the current one until taken, then offer the next or idle
  always @(negedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
      event_ready <= 1'b0;
    end else begin
      if (!scan_valid || scan_fired) begin
        if (scan_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          scan_valid <= 1'b1;
          scan_code <= scan_backlog.pop_front();
        end else begin
          scan_valid <= 1'b0;
        end
      end
      event_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Check events against the oldest expectation, then predict from taken requests
  always @(posedge clk) begin
    if (rst) begin
      scan_fired <= 1'b0;
    end else begin
      scan_fired <= scan_valid && scan_ready;
      if (event_valid && event_ready) begin
        if (due_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind %0d ticks %0d key %h",
                                    event_kind, event_ticks, event_key));
        end else begin
          want_event = due_events.pop_front();
          if (event_kind !== want_event.kind)
            report_mismatch($sformatf("kind got %0d want %0d", event_kind, want_event.kind));
          if (event_ticks !== want_event.ticks)
            report_mismatch($sformatf("ticks got %0d want %0d", event_ticks, want_event.ticks));
          if (event_key !== want_event.key)
            report_mismatch($sformatf("key got %h want %h", event_key, want_event.key));
        end
      end
      if (scan_valid && scan_ready) begin
        scans_done++;
        debounce_tick(scan_code);
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // clean press of the all-ones key, then held one tick
    repeat (4) queue_scan(16'hFFFF);
    // glitch that returns to the same key keeps it pressed
    queue_scan(16'hAAAA);
    repeat (2) queue_scan(16'hFFFF);
    // glitch to a third code that settles: release, then press of the new key
    queue_scan(16'h5555);
    repeat (3) queue_scan(16'hAAAA);
    // release to the idle code
    repeat (3) queue_scan(16'h0000);
    // press of the idle code itself, reached through a double change
    queue_scan(16'h0001);
    queue_scan(16'h8000);
    repeat (4) queue_scan(16'h0000);
    wait_drained();

    // filter of one tick with periodic held events
    write_reg(kdlp_pkg::REG_FILTER_TICKS, 32'd1);
    write_reg(kdlp_pkg::REG_LONG_PRESS_EN, 32'd1);
    write_reg(kdlp_pkg::REG_RELEASED_CODE, 32'hABCD_5555);
    queue_key_strokes(500);
    wait_drained();

    // zero filter; a write to the unused address changes nothing
    write_reg(kdlp_pkg::REG_FILTER_TICKS, 32'd0);
    write_reg(kdlp_pkg::REG_LONG_PRESS_EN, 32'hFFFF_FFFE);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    queue_key_strokes(300);
    wait_drained();

    // swap idling: slow sender, eager receiver
    send_idle_pct = 53;
    recv_stall_pct = 10;
    write_reg(kdlp_pkg::REG_FILTER_TICKS, $urandom_range(2, 6));
    write_reg(kdlp_pkg::REG_LONG_PRESS_EN, 32'd1);
    write_reg(kdlp_pkg::REG_RELEASED_CODE, $urandom);
    queue_key_strokes(300);
    // hold off the sender until every event is out
    wait_drained();
    queue_key_strokes(300);
    wait_drained();

    // no idling
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(kdlp_pkg::REG_FILTER_TICKS, 32'd2);
    write_reg(kdlp_pkg::REG_RELEASED_CODE, 32'd0);
    queue_key_strokes(550);
    wait_drained();

    if (mismatches == 0 && due_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
